// ===== rtl/usc_pkg.sv =====
// ---------------------------------------------------------------------------
// usc_pkg
// Shared types and constants for the seconds-to-calendar converter.
// ---------------------------------------------------------------------------
package usc_pkg;

  localparam int unsigned EPOCH_W    = 32;
  localparam int unsigned YEAR_W     = 12;
  localparam int unsigned MONTH_W    = 4;
  localparam int unsigned DAY_W      = 5;
  localparam int unsigned HOUR_W     = 5;
  localparam int unsigned MINUTE_W   = 6;

  // Working accumulator: holds a partial remainder (< 86400) or a day count
  localparam int unsigned ACC_W      = 17;
  // Trial operand of the shared subtractor, one bit wider
  localparam int unsigned OPD_W      = ACC_W + 1;
  // Day quotient / dividend shift register
  localparam int unsigned SH_W       = 16;

  localparam logic [OPD_W-1:0] SEC_PER_DAY  = OPD_W'(86400);
  localparam logic [OPD_W-1:0] SEC_PER_HOUR = OPD_W'(3600);
  localparam logic [OPD_W-1:0] SEC_PER_MIN  = OPD_W'(60);
  localparam logic [OPD_W-1:0] DAYS_LEAP    = OPD_W'(366);
  localparam logic [OPD_W-1:0] DAYS_COMMON  = OPD_W'(365);

  localparam logic [YEAR_W-1:0]  EPOCH_YEAR = YEAR_W'(1970);
  // 1970 mod 4, mod 100, mod 400
  localparam logic [1:0]         EPOCH_MOD4   = 2'd2;
  localparam logic [6:0]         EPOCH_MOD100 = 7'd70;
  localparam logic [8:0]         EPOCH_MOD400 = 9'd370;
  localparam logic [6:0]         MOD100_LAST  = 7'd99;
  localparam logic [8:0]         MOD400_LAST  = 9'd399;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  // Iteration counts of the three divisions (quotient bits)
  localparam logic [4:0] DAY_STEPS  = 5'd16;
  localparam logic [4:0] HOUR_STEPS = 5'd5;
  localparam logic [4:0] MIN_STEPS  = 5'd6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DAY,
    ST_HOUR,
    ST_MIN,
    ST_YEAR,
    ST_MONTH,
    ST_DONE
  } usc_state_t;

  // Days in a month; February gains a day in leap years
  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                  input logic              leap);
    logic [DAY_W-1:0] d;
    unique case (m)
      MONTH_FEB:                 d = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   d = 5'd30;
      default:                   d = 5'd31;
    endcase
    return d;
  endfunction

endpackage

// ===== rtl/unix_seconds_to_calendar.sv =====
// ---------------------------------------------------------------------------
// unix_seconds_to_calendar
// Converts unsigned Unix seconds into Gregorian year, month, day, hour, minute.
// ---------------------------------------------------------------------------
// One item is converted at a time through a single 18-bit subtract-and-compare
// unit under a small sequencer. After a load step, restoring division by 86400
// yields a 16-bit day quotient, then division of the remainder gives a 5-bit
// hour and a 6-bit minute quotient; a year loop then subtracts one year's days
// per whole year since 1970 (up to 136) and a month loop subtracts month lengths
// up to the month of the result. in_ready is high only while the sequencer is
// idle. The result sits in its own output register, so a new item may be taken
// while the previous result waits for out_ready. Seconds within the minute are
// dropped; every 32-bit input is legal and the largest gives 2106-02-07 06:28.
// ---------------------------------------------------------------------------
module unix_seconds_to_calendar (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [usc_pkg::EPOCH_W-1:0]   in_epoch_seconds,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [usc_pkg::YEAR_W-1:0]    out_cal_year,
  output logic [usc_pkg::MONTH_W-1:0]   out_cal_month,
  output logic [usc_pkg::DAY_W-1:0]     out_cal_day,
  output logic [usc_pkg::HOUR_W-1:0]    out_cal_hour,
  output logic [usc_pkg::MINUTE_W-1:0]  out_cal_minute
);
  import usc_pkg::*;

  // Sequencer
  usc_state_t state_r, state_nxt;

  // Working registers
  logic [ACC_W-1:0]    acc_r, acc_nxt;       // partial remainder, then days left
  logic [SH_W-1:0]     sh_r, sh_nxt;         // dividend bits out, quotient bits in
  logic [3:0]          cnt_r, cnt_nxt;       // division step counter
  logic [SH_W-1:0]     days_r, days_nxt;     // whole days since epoch
  logic [YEAR_W-1:0]   year_r, year_nxt;
  logic [1:0]          m4_r, m4_nxt;         // year mod 4
  logic [6:0]          m100_r, m100_nxt;     // year mod 100
  logic [8:0]          m400_r, m400_nxt;     // year mod 400
  logic [MONTH_W-1:0]  month_r, month_nxt;
  logic [HOUR_W-1:0]   hour_r, hour_nxt;
  logic [MINUTE_W-1:0] minute_r, minute_nxt;

  // Output register
  logic                out_valid_r, out_valid_nxt;
  logic [YEAR_W-1:0]   o_year_r, o_year_nxt;
  logic [MONTH_W-1:0]  o_month_r, o_month_nxt;
  logic [DAY_W-1:0]    o_day_r, o_day_nxt;
  logic [HOUR_W-1:0]   o_hour_r, o_hour_nxt;
  logic [MINUTE_W-1:0] o_minute_r, o_minute_nxt;

  // Shared subtract unit
  logic [OPD_W-1:0]    opd_a, opd_b;
  logic [OPD_W:0]      diff;
  logic                geq;
  logic [ACC_W-1:0]    rem_step;
  logic [SH_W-1:0]     quo_step;
  logic                leap;
  logic                last_step;
  logic                out_free;

  assign leap      = ((m4_r == 2'd0) && (m100_r != 7'd0)) || (m400_r == 9'd0);
  assign last_step = (cnt_r == 4'd0);
  assign out_free  = !out_valid_r || out_ready;

  // Operand select: division steps shift the next dividend bit in,
  // year and month steps compare the day count against a length
  always_comb begin
    opd_a = {acc_r, sh_r[SH_W-1]};
    opd_b = '0;
    unique case (state_r)
      ST_DAY:   opd_b = SEC_PER_DAY;
      ST_HOUR:  opd_b = SEC_PER_HOUR;
      ST_MIN:   opd_b = SEC_PER_MIN;
      ST_YEAR: begin
        opd_a = {1'b0, acc_r};
        opd_b = leap ? DAYS_LEAP : DAYS_COMMON;
      end
      ST_MONTH: begin
        opd_a = {1'b0, acc_r};
        opd_b = OPD_W'(month_days(month_r, leap));
      end
      default: opd_a = {1'b0, acc_r};
    endcase
  end

  assign diff     = {1'b0, opd_a} - {1'b0, opd_b};
  assign geq      = !diff[OPD_W];
  assign rem_step = geq ? diff[ACC_W-1:0] : opd_a[ACC_W-1:0];
  assign quo_step = {sh_r[SH_W-2:0], geq};

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_valid)  state_nxt = ST_DAY;
      ST_DAY:   if (last_step) state_nxt = ST_HOUR;
      ST_HOUR:  if (last_step) state_nxt = ST_MIN;
      ST_MIN:   if (last_step) state_nxt = ST_YEAR;
      ST_YEAR:  if (!geq)      state_nxt = ST_MONTH;
      ST_MONTH: if ((month_r == MONTH_DEC) || !geq) state_nxt = ST_DONE;
      ST_DONE:  if (out_free)  state_nxt = ST_IDLE;
      default:                 state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    acc_nxt       = acc_r;
    sh_nxt        = sh_r;
    cnt_nxt       = cnt_r;
    days_nxt      = days_r;
    year_nxt      = year_r;
    m4_nxt        = m4_r;
    m100_nxt      = m100_r;
    m400_nxt      = m400_r;
    month_nxt     = month_r;
    hour_nxt      = hour_r;
    minute_nxt    = minute_r;
    out_valid_nxt = out_valid_r && !out_ready;
    o_year_nxt    = o_year_r;
    o_month_nxt   = o_month_r;
    o_day_nxt     = o_day_r;
    o_hour_nxt    = o_hour_r;
    o_minute_nxt  = o_minute_r;
    in_ready      = (state_r == ST_IDLE);

    unique case (state_r)
      ST_IDLE: begin
        // quotient < 2^16, so the top half is already a valid remainder
        acc_nxt   = {1'b0, in_epoch_seconds[EPOCH_W-1:SH_W]};
        sh_nxt    = in_epoch_seconds[SH_W-1:0];
        cnt_nxt   = 4'(DAY_STEPS - 5'd1);
        year_nxt  = EPOCH_YEAR;
        m4_nxt    = EPOCH_MOD4;
        m100_nxt  = EPOCH_MOD100;
        m400_nxt  = EPOCH_MOD400;
        month_nxt = MONTH_JAN;
      end
      ST_DAY: begin
        acc_nxt = rem_step;
        sh_nxt  = quo_step;
        cnt_nxt = cnt_r - 4'd1;
        if (last_step) begin
          days_nxt = quo_step;
          // seconds of day < 86400: hour quotient has 5 bits
          acc_nxt  = ACC_W'(rem_step >> HOUR_STEPS);
          sh_nxt   = {rem_step[4:0], 11'd0};
          cnt_nxt  = 4'(HOUR_STEPS - 5'd1);
        end
      end
      ST_HOUR: begin
        acc_nxt = rem_step;
        sh_nxt  = quo_step;
        cnt_nxt = cnt_r - 4'd1;
        if (last_step) begin
          hour_nxt = quo_step[HOUR_W-1:0];
          acc_nxt  = ACC_W'(rem_step >> MIN_STEPS);
          sh_nxt   = {rem_step[5:0], 10'd0};
          cnt_nxt  = 4'(MIN_STEPS - 5'd1);
        end
      end
      ST_MIN: begin
        acc_nxt = rem_step;
        sh_nxt  = quo_step;
        cnt_nxt = cnt_r - 4'd1;
        if (last_step) begin
          minute_nxt = quo_step[MINUTE_W-1:0];
          acc_nxt    = {1'b0, days_r};
        end
      end
      ST_YEAR: begin
        if (geq) begin
          acc_nxt  = diff[ACC_W-1:0];
          year_nxt = year_r + YEAR_W'(1);
          m4_nxt   = m4_r + 2'd1;
          m100_nxt = (m100_r == MOD100_LAST) ? 7'd0 : m100_r + 7'd1;
          m400_nxt = (m400_r == MOD400_LAST) ? 9'd0 : m400_r + 9'd1;
        end
      end
      ST_MONTH: begin
        if ((month_r != MONTH_DEC) && geq) begin
          acc_nxt   = diff[ACC_W-1:0];
          month_nxt = month_r + MONTH_W'(1);
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          o_year_nxt    = year_r;
          o_month_nxt   = month_r;
          o_day_nxt     = acc_r[DAY_W-1:0] + DAY_W'(1);
          o_hour_nxt    = hour_r;
          o_minute_nxt  = minute_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    sh_r       <= sh_nxt;
    cnt_r      <= cnt_nxt;
    days_r     <= days_nxt;
    year_r     <= year_nxt;
    m4_r       <= m4_nxt;
    m100_r     <= m100_nxt;
    m400_r     <= m400_nxt;
    month_r    <= month_nxt;
    hour_r     <= hour_nxt;
    minute_r   <= minute_nxt;
    o_year_r   <= o_year_nxt;
    o_month_r  <= o_month_nxt;
    o_day_r    <= o_day_nxt;
    o_hour_r   <= o_hour_nxt;
    o_minute_r <= o_minute_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_cal_year   = o_year_r;
  assign out_cal_month  = o_month_r;
  assign out_cal_day    = o_day_r;
  assign out_cal_hour   = o_hour_r;
  assign out_cal_minute = o_minute_r;

`ifndef SYNTHESIS
  // Restoring division keeps the partial remainder below the divisor
  a_day_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_HOUR) |-> ({1'b0, acc_r} < SEC_PER_HOUR))
    else $error("hour partial remainder out of range");

  // After the year loop fewer than a year's days remain
  a_month_days: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MONTH) |-> ({1'b0, acc_r} < DAYS_LEAP))
    else $error("day count too large in month loop");

  a_out_month: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_cal_month >= MONTH_JAN) && (out_cal_month <= MONTH_DEC)))
    else $error("month out of range");

  a_out_time: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_cal_hour <= 5'd23) && (out_cal_minute <= 6'd59)
                   && (out_cal_day != 5'd0)))
    else $error("time of day or day of month out of range");

  // A result is loaded only from the final state
  a_load_src: assert property (@(posedge clk) disable iff (!rst_n)
    ($rose(out_valid_r)) |-> ($past(state_r) == ST_DONE))
    else $error("result loaded outside completion");
`endif

endmodule
